// ===== rtl/plti_pkg.sv =====
// ----------------------------------------------------------------------------
// plti_pkg
// Shared constants and types of the piecewise linear table interpolator.
// ----------------------------------------------------------------------------
package plti_pkg;

  localparam int MaxPoints = 16;
  localparam int IdxW      = $clog2(MaxPoints);
  localparam int CntW      = 5;
  localparam int DataW     = 32;
  localparam int EntryW    = 2 * DataW;

  localparam logic [CntW-1:0]  PointCountReset = CntW'(2);
  localparam logic [DataW-1:0] OneQ16          = 32'h0001_0000;

  localparam logic CmdWrite = 1'b0;
  localparam logic CmdEval  = 1'b1;

  typedef struct packed {
    logic             start;
    logic [DataW-1:0] mag;
    logic [DataW-1:0] num;
    logic [DataW-1:0] den;
  } md_req_t;

  typedef struct packed {
    logic             done;
    logic [DataW-1:0] quo;
  } md_rsp_t;

endpackage

// ===== rtl/plti_cfg_if.sv =====
// ----------------------------------------------------------------------------
// plti_cfg_if
// Configuration write channel carrying the point count register.
// ----------------------------------------------------------------------------
interface plti_cfg_if
  import plti_pkg::*;
;
  logic            valid;
  logic            ready;
  logic [CntW-1:0] point_count;

  modport source (output valid, output point_count, input ready);
  modport sink   (input valid, input point_count, output ready);
endinterface

// ===== rtl/plti_in_if.sv =====
// ----------------------------------------------------------------------------
// plti_in_if
// Input channel: table write or evaluate transaction.
// ----------------------------------------------------------------------------
interface plti_in_if
  import plti_pkg::*;
;
  logic                    valid;
  logic                    ready;
  logic                    command;
  logic [IdxW-1:0]         entry_index;
  logic signed [DataW-1:0] entry_x;
  logic signed [DataW-1:0] entry_y;
  logic signed [DataW-1:0] query_x;

  modport source (output valid, output command, output entry_index, output entry_x,
                  output entry_y, output query_x, input ready);
  modport sink   (input valid, input command, input entry_index, input entry_x,
                  input entry_y, input query_x, output ready);
endinterface

// ===== rtl/plti_out_if.sv =====
// ----------------------------------------------------------------------------
// plti_out_if
// Result channel: interpolated value and no-segment flag.
// ----------------------------------------------------------------------------
interface plti_out_if
  import plti_pkg::*;
;
  logic                    valid;
  logic                    ready;
  logic signed [DataW-1:0] result_y;
  logic                    no_segment;

  modport source (output valid, output result_y, output no_segment, input ready);
  modport sink   (input valid, input result_y, input no_segment, output ready);
endinterface

// ===== rtl/piecewise_linear_table_interpolator.sv =====
// ----------------------------------------------------------------------------
// piecewise_linear_table_interpolator
// Table write: the next transaction may follow at once.
// Evaluate: tests the last breakpoint (at or above: its y), then the first (at or
// below: its y), then searches segments in order; no matching segment gives
// no_segment with 1.0; on segment a (1..15) a multiply and 32-step serial divide.
// A result held by a stalled receiver holds the input.
// Reset clears control and sets point_count to 2; table undefined until written.
// ----------------------------------------------------------------------------
module piecewise_linear_table_interpolator
  import plti_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  plti_cfg_if.sink   cfg_i,
  plti_in_if.sink    in_i,
  plti_out_if.source out_o
);

  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_LAST  = 6'b000010,
    ST_FIRST = 6'b000100,
    ST_SRCH  = 6'b001000,
    ST_CALC  = 6'b010000,
    ST_DONE  = 6'b100000
  } state_e;

  state_e                  state_q, state_d;
  logic [CntW-1:0]         pcount_q;
  logic [CntW-1:0]         n_eff;
  logic [IdxW-1:0]         n_last;

  logic signed [DataW-1:0] q_q, q_d;
  logic [IdxW-1:0]         last_q, last_d;
  logic [IdxW-1:0]         idx_q, idx_d;
  logic signed [DataW-1:0] prev_x_q, prev_x_d;
  logic signed [DataW-1:0] prev_y_q, prev_y_d;
  logic signed [DataW-1:0] y0_q, y0_d;
  logic                    neg_q, neg_d;
  logic [DataW-1:0]        res_q, res_d;
  logic                    miss_q, miss_d;
  md_req_t                 md_req_q, md_req_d;
  md_rsp_t                 md_rsp;

  logic                    out_valid_q;
  logic [DataW-1:0]        out_res_q;
  logic                    out_miss_q;
  logic                    out_load;

  logic                    in_acc;
  logic                    ram_we;
  logic                    ram_re;
  logic [IdxW-1:0]         ram_raddr;
  logic [EntryW-1:0]       ram_rdata;
  logic signed [DataW-1:0] rd_x, rd_y;

  logic signed [DataW:0]   dy;
  logic [DataW:0]          num_w, den_w;
  logic [DataW-1:0]        mag;
  logic signed [DataW+1:0] sum;
  logic [DataW-1:0]        sat;

  // configuration
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pcount_q <= PointCountReset;
    end else if (cfg_i.valid) begin
      pcount_q <= cfg_i.point_count;
    end
  end

  always_comb begin
    if (pcount_q == '0) begin
      n_eff = CntW'(1);
    end else if (pcount_q > CntW'(MaxPoints)) begin
      n_eff = CntW'(MaxPoints);
    end else begin
      n_eff = pcount_q;
    end
  end
  assign n_last = IdxW'(n_eff - CntW'(1));

  // breakpoint table: {x, y} per entry
  assign in_i.ready = (state_q == ST_IDLE);
  assign in_acc     = in_i.valid && in_i.ready;
  assign ram_we     = in_acc && (in_i.command == CmdWrite);

  plti_ram #(
    .Width (EntryW),
    .Depth (MaxPoints)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (in_i.entry_index),
    .wdata_i ({in_i.entry_x, in_i.entry_y}),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign rd_x = ram_rdata[EntryW-1:DataW];
  assign rd_y = ram_rdata[DataW-1:0];

  // segment operands
  assign dy    = {rd_y[DataW-1], rd_y} - {prev_y_q[DataW-1], prev_y_q};
  assign num_w = {q_q[DataW-1], q_q} - {prev_x_q[DataW-1], prev_x_q};
  assign den_w = {rd_x[DataW-1], rd_x} - {prev_x_q[DataW-1], prev_x_q};
  assign mag   = dy[DataW] ? DataW'(-dy) : dy[DataW-1:0];

  plti_muldiv u_muldiv (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (md_req_q),
    .rsp_o  (md_rsp)
  );

  // y0 + signed quotient, saturated
  assign sum = {{2{y0_q[DataW-1]}}, y0_q}
             + (neg_q ? -{2'b00, md_rsp.quo} : {2'b00, md_rsp.quo});

  always_comb begin
    if (sum[DataW+1:DataW-1] == 3'b000 || sum[DataW+1:DataW-1] == 3'b111) begin
      sat = sum[DataW-1:0];
    end else if (sum[DataW+1]) begin
      sat = {1'b1, {(DataW-1){1'b0}}};
    end else begin
      sat = {1'b0, {(DataW-1){1'b1}}};
    end
  end

  assign out_load = (state_q == ST_DONE) && (!out_valid_q || out_o.ready);

  // sequencer
  always_comb begin
    state_d        = state_q;
    ram_re         = 1'b0;
    ram_raddr      = idx_q;
    q_d            = q_q;
    last_d         = last_q;
    idx_d          = idx_q;
    prev_x_d       = prev_x_q;
    prev_y_d       = prev_y_q;
    y0_d           = y0_q;
    neg_d          = neg_q;
    res_d          = res_q;
    miss_d         = miss_q;
    md_req_d       = md_req_q;
    md_req_d.start = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (in_acc && (in_i.command == CmdEval)) begin
          ram_re    = 1'b1;
          ram_raddr = n_last;
          q_d       = in_i.query_x;
          last_d    = n_last;
          state_d   = ST_LAST;
        end
      end
      ST_LAST: begin
        if (q_q >= rd_x) begin
          res_d   = rd_y;
          miss_d  = 1'b0;
          state_d = ST_DONE;
        end else begin
          ram_re    = 1'b1;
          ram_raddr = '0;
          state_d   = ST_FIRST;
        end
      end
      ST_FIRST: begin
        if (q_q <= rd_x) begin
          res_d   = rd_y;
          miss_d  = 1'b0;
          state_d = ST_DONE;
        end else begin
          ram_re    = 1'b1;
          ram_raddr = IdxW'(1);
          idx_d     = IdxW'(1);
          prev_x_d  = rd_x;
          prev_y_d  = rd_y;
          state_d   = ST_SRCH;
        end
      end
      ST_SRCH: begin
        if ((q_q >= prev_x_q) && (q_q < rd_x)) begin
          y0_d           = prev_y_q;
          neg_d          = dy[DataW];
          md_req_d.start = 1'b1;
          md_req_d.mag   = mag;
          md_req_d.num   = num_w[DataW-1:0];
          md_req_d.den   = den_w[DataW-1:0];
          state_d        = ST_CALC;
        end else if (idx_q == last_q) begin
          res_d   = OneQ16;
          miss_d  = 1'b1;
          state_d = ST_DONE;
        end else begin
          ram_re    = 1'b1;
          ram_raddr = idx_q + IdxW'(1);
          idx_d     = idx_q + IdxW'(1);
          prev_x_d  = rd_x;
          prev_y_d  = rd_y;
        end
      end
      ST_CALC: begin
        if (md_rsp.done) begin
          res_d   = sat;
          miss_d  = 1'b0;
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_load) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      md_req_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      md_req_q <= md_req_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    q_q          <= q_d;
    last_q       <= last_d;
    idx_q        <= idx_d;
    prev_x_q     <= prev_x_d;
    prev_y_q     <= prev_y_d;
    y0_q         <= y0_d;
    neg_q        <= neg_d;
    res_q        <= res_d;
    miss_q       <= miss_d;
    if (out_load) begin
      out_res_q  <= res_q;
      out_miss_q <= miss_q;
    end
  end

  assign out_o.valid      = out_valid_q;
  assign out_o.result_y   = out_res_q;
  assign out_o.no_segment = out_miss_q;

endmodule

// ===== rtl/plti_ram.sv =====
// ----------------------------------------------------------------------------
// plti_ram
// Single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module plti_ram #(
  parameter int Width = 64,
  parameter int Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

// ===== rtl/plti_muldiv.sv =====
// ----------------------------------------------------------------------------
// plti_muldiv
// Serial unit computing floor(mag * num / den): two half-width partial
// products, then a restoring divide producing one quotient bit per cycle.
// ----------------------------------------------------------------------------
module plti_muldiv
  import plti_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  md_req_t req_i,
  output md_rsp_t rsp_o
);

  localparam int Half  = DataW / 2;
  localparam int StepW = $clog2(DataW);

  typedef enum logic [5:0] {
    MD_IDLE  = 6'b000001,
    MD_MUL0  = 6'b000010,
    MD_MUL1  = 6'b000100,
    MD_MUL2  = 6'b001000,
    MD_DINIT = 6'b010000,
    MD_DIV   = 6'b100000
  } md_state_e;

  md_state_e                 state_q, state_d;
  logic [StepW-1:0]          cnt_q, cnt_d;
  logic                      done_q, done_d;
  logic [DataW+Half-1:0]     pp_q, pp_d;
  logic [2*DataW-1:0]        prod_q, prod_d;
  logic [DataW-1:0]          rem_q, rem_d;
  logic [DataW-1:0]          dvd_q, dvd_d;
  logic [DataW:0]            trial;
  logic                      ge;

  assign trial = {rem_q, dvd_q[DataW-1]};
  assign ge    = trial >= {1'b0, req_i.den};

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    done_d  = 1'b0;
    pp_d    = pp_q;
    prod_d  = prod_q;
    rem_d   = rem_q;
    dvd_d   = dvd_q;
    case (state_q)
      MD_IDLE: begin
        if (req_i.start) begin
          state_d = MD_MUL0;
        end
      end
      MD_MUL0: begin
        pp_d    = req_i.mag * req_i.num[Half-1:0];
        state_d = MD_MUL1;
      end
      MD_MUL1: begin
        prod_d  = (2*DataW)'(pp_q);
        pp_d    = req_i.mag * req_i.num[DataW-1:Half];
        state_d = MD_MUL2;
      end
      MD_MUL2: begin
        prod_d  = prod_q + {pp_q, {Half{1'b0}}};
        state_d = MD_DINIT;
      end
      MD_DINIT: begin
        rem_d   = prod_q[2*DataW-1:DataW];
        dvd_d   = prod_q[DataW-1:0];
        cnt_d   = '0;
        state_d = MD_DIV;
      end
      MD_DIV: begin
        rem_d = ge ? DataW'(trial - {1'b0, req_i.den}) : trial[DataW-1:0];
        dvd_d = {dvd_q[DataW-2:0], ge};
        cnt_d = cnt_q + StepW'(1);
        if (cnt_q == StepW'(DataW - 1)) begin
          done_d  = 1'b1;
          state_d = MD_IDLE;
        end
      end
      default: begin
        state_d = MD_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= MD_IDLE;
      cnt_q   <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pp_q   <= pp_d;
    prod_q <= prod_d;
    rem_q  <= rem_d;
    dvd_q  <= dvd_d;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quo  = dvd_q;

endmodule

// ===== tb/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the piecewise linear table interpolator. Loads
// breakpoint tables, sweeps point_count, and runs evaluate transactions under
// several valid/ready idle mixes. Each result is checked against an in-bench
// Q16.16 interpolation predictor.
// ----------------------------------------------------------------------------
module testbench
  import plti_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic signed [DataW-1:0] result_y;
    logic                    no_segment;
  } interp_value_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  plti_cfg_if cfg_bus ();
  plti_in_if  in_bus ();
  plti_out_if out_bus ();

  piecewise_linear_table_interpolator dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_bus),
    .in_i   (in_bus),
    .out_o  (out_bus)
  );

  logic signed [DataW-1:0] bp_x [MaxPoints];
  logic signed [DataW-1:0] bp_y [MaxPoints];
  logic [CntW-1:0]         point_count_q;
  interp_value_t           pending_interp_q [$];

  int sender_idle_pct    = 0;
  int receiver_stall_pct = 0;
  int error_count        = 0;
  int result_count       = 0;
  int write_count        = 0;
  int setting_count      = 0;

  always #10 clk_i = ~clk_i;

  always @(negedge clk_i) begin
    out_bus.ready <= ($urandom_range(0, 99) >= receiver_stall_pct);
  end

  function automatic int used_points();
    int n;
    n = int'(point_count_q);
    if (n == 0) n = 1;
    if (n > MaxPoints) n = MaxPoints;
    return n;
  endfunction

  function automatic interp_value_t interpolate_q16(logic signed [DataW-1:0] qx);
    interp_value_t   r;
    int              n;
    longint          x0, x1, y0, dy, step, sum;
    longint unsigned mag, num, den;
    n            = used_points();
    r.result_y   = OneQ16;
    r.no_segment = 1'b1;
    if (qx >= bp_x[n-1]) begin
      r.result_y   = bp_y[n-1];
      r.no_segment = 1'b0;
    end else if (qx <= bp_x[0]) begin
      r.result_y   = bp_y[0];
      r.no_segment = 1'b0;
    end else begin
      for (int a = 1; a < n; a++) begin
        x0 = bp_x[a-1];
        x1 = bp_x[a];
        if (r.no_segment && qx >= x0 && qx < x1) begin
          y0   = bp_y[a-1];
          dy   = longint'(bp_y[a]) - y0;
          mag  = (dy < 0) ? -dy : dy;
          num  = qx - x0;
          den  = x1 - x0;
          step = longint'((mag * num) / den);
          if (dy < 0) step = -step;
          sum = y0 + step;
          if (sum > 64'sh7FFF_FFFF) sum = 64'sh7FFF_FFFF;
          else if (sum < -64'sh8000_0000) sum = -64'sh8000_0000;
          r.result_y   = DataW'(sum);
          r.no_segment = 1'b0;
        end
      end
    end
    return r;
  endfunction

  always @(posedge clk_i) begin : check_results
    interp_value_t want;
    if (rst_ni === 1'b1 && out_bus.valid === 1'b1 && out_bus.ready === 1'b1) begin
      result_count++;
      if (pending_interp_q.size() == 0) begin
        error_count++;
        if (error_count <= 50)
          $display("%0t: unexpected result, expected none, actual y=%h no_segment=%b",
                   $time, out_bus.result_y, out_bus.no_segment);
      end else begin
        want = pending_interp_q.pop_front();
        if (out_bus.result_y !== want.result_y) begin
          error_count++;
          if (error_count <= 50)
            $display("%0t: result_y mismatch, expected %h actual %h",
                     $time, want.result_y, out_bus.result_y);
        end
        if (out_bus.no_segment !== want.no_segment) begin
          error_count++;
          if (error_count <= 50)
            $display("%0t: no_segment mismatch, expected %b actual %b",
                     $time, want.no_segment, out_bus.no_segment);
        end
      end
    end
  end

  // Called at a falling edge; returns at the falling edge after acceptance
  // with valid still high, so a following call may continue back to back.
  task automatic send_item(input logic cmd, input logic [IdxW-1:0] idx,
                           input logic signed [DataW-1:0] ex, ey, qx);
    while ($urandom_range(0, 99) < sender_idle_pct) begin
      in_bus.valid <= 1'b0;
      @(negedge clk_i);
    end
    in_bus.valid       <= 1'b1;
    in_bus.command     <= cmd;
    in_bus.entry_index <= idx;
    in_bus.entry_x     <= ex;
    in_bus.entry_y     <= ey;
    in_bus.query_x     <= qx;
    do @(posedge clk_i); while (in_bus.ready !== 1'b1);
    if (cmd == CmdWrite) begin
      bp_x[idx] = ex;
      bp_y[idx] = ey;
      write_count++;
    end else begin
      pending_interp_q = {pending_interp_q, interpolate_q16(qx)};
    end
    @(negedge clk_i);
  endtask

  task automatic write_entry(input int idx, input logic signed [DataW-1:0] ex, ey);
    send_item(CmdWrite, IdxW'(idx), ex, ey, $urandom);
  endtask

  task automatic evaluate_at(input logic signed [DataW-1:0] qx);
    send_item(CmdEval, IdxW'($urandom), $urandom, $urandom, qx);
  endtask

  // Writes carry no result, so allow the block's longest evaluate time as well.
  task automatic drain_results();
    in_bus.valid <= 1'b0;
    while (pending_interp_q.size() != 0) @(negedge clk_i);
    repeat (64) @(negedge clk_i);
  endtask

  task automatic set_point_count(input logic [CntW-1:0] count);
    drain_results();
    cfg_bus.valid       <= 1'b1;
    cfg_bus.point_count <= count;
    do @(posedge clk_i); while (cfg_bus.ready !== 1'b1);
    point_count_q = count;
    setting_count++;
    @(negedge clk_i);
    cfg_bus.valid <= 1'b0;
  endtask

  // kind 0: sorted, full range; kind 1: sorted, narrow steps with repeats;
  // otherwise unsorted with many equal abscissas
  task automatic load_table(input int kind);
    int xs [MaxPoints];
    int base;
    base = $urandom;
    foreach (xs[i]) begin
      case (kind)
        0: xs[i] = $urandom;
        1: begin
          base += $urandom_range(0, 32'h3_0000);
          xs[i] = base;
        end
        default: xs[i] = ($urandom_range(0, 7) - 4) * 32'sh1_0000;
      endcase
    end
    if (kind < 2) xs.sort();
    foreach (xs[i]) write_entry(i, xs[i], $urandom);
  endtask

  function automatic logic signed [DataW-1:0] random_query();
    int k;
    k = $urandom_range(0, used_points() - 1);
    case ($urandom_range(0, 3))
      0:       return $urandom;
      1:       return bp_x[k];
      default: return bp_x[k] + $urandom_range(0, 32'h4_0000) - 32'h2_0000;
    endcase
  endfunction

  task automatic test_table_fill();
    write_entry(0, 32'sh8000_0000, 32'sh7FFF_FFFF);
    write_entry(1, 32'sh0000_0000, 32'sh8000_0000);
    for (int i = 2; i < MaxPoints - 1; i++)
      write_entry(i, i <<< 16, (i % 2) ? -(i <<< 16) : (i <<< 20));
    write_entry(MaxPoints - 1, 32'sh7FFF_FFFF, 32'sh0000_0000);
  endtask

  task automatic test_end_clamps();
    evaluate_at(32'sh8000_0000);
    evaluate_at(32'sh7FFF_FFFF);
    evaluate_at(32'sh0000_0000);
    evaluate_at(32'shFFFF_FFFF);
    evaluate_at(32'sh8000_0001);
    evaluate_at(32'shC000_0000);
    set_point_count(CntW'(MaxPoints));
    evaluate_at(32'sh7FFF_FFFE);
    evaluate_at(32'sh0002_8000);
    evaluate_at(32'sh0003_0000);
    evaluate_at(32'sh7FFF_FFFF);
  endtask

  task automatic test_count_limits();
    set_point_count('0);
    evaluate_at(32'sh8000_0000);
    evaluate_at(32'sh7FFF_FFFF);
    set_point_count('1);
    evaluate_at(32'sh7FFF_FFFF);
    evaluate_at(32'sh0005_4000);
    set_point_count(CntW'(1));
    evaluate_at(32'sh0000_0000);
  endtask

  // equal adjacent abscissas, then a descending step
  task automatic test_unsorted_table();
    write_entry(0, 32'sh0000_0000, 32'sh0001_0000);
    write_entry(1, 32'sh0000_0000, 32'sh0002_0000);
    write_entry(2, 32'sh0005_0000, -32'sh0003_0000);
    write_entry(3, 32'sh0002_0000, 32'sh7FFF_FFFF);
    set_point_count(CntW'(4));
    evaluate_at(32'sh0001_0000);
    evaluate_at(32'sh0003_0000);
    evaluate_at(32'sh0001_8000);
  endtask

  task automatic test_random_traffic(input int sender_pct, input int receiver_pct);
    logic [CntW-1:0] count;
    sender_idle_pct    = sender_pct;
    receiver_stall_pct = receiver_pct;
    repeat (3) begin
      case ($urandom_range(0, 5))
        0:       count = '0;
        1:       count = CntW'(1);
        2:       count = CntW'(MaxPoints);
        3:       count = '1;
        default: count = CntW'($urandom_range(2, MaxPoints));
      endcase
      set_point_count(count);
      load_table(($urandom_range(0, 9) < 2) ? 2 : $urandom_range(0, 1));
      repeat (60) begin
        if ($urandom_range(0, 99) < 6) write_entry($urandom_range(0, MaxPoints - 1),
                                                   $urandom, $urandom);
        else evaluate_at(random_query());
      end
    end
  endtask

  initial begin
    rst_ni              = 1'b0;
    cfg_bus.valid       = 1'b0;
    cfg_bus.point_count = PointCountReset;
    in_bus.valid        = 1'b0;
    in_bus.command      = CmdWrite;
    in_bus.entry_index  = '0;
    in_bus.entry_x      = '0;
    in_bus.entry_y      = '0;
    in_bus.query_x      = '0;
    point_count_q       = PointCountReset;
    repeat (7) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    test_table_fill();
    test_end_clamps();
    test_count_limits();
    test_unsorted_table();
    test_random_traffic(0, 0);
    test_random_traffic(46, 0);
    test_random_traffic(0, 46);
    test_random_traffic(17, 17);
    drain_results();

    $display("testbench: %0d results checked, %0d table writes, %0d point_count writes",
             result_count, write_count, setting_count);
    $display("testbench: sorted, narrow and unsorted tables; counts 0 to 31; four idle mixes");
    if (error_count == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("testbench: FAIL");
    $finish;
  end

endmodule
